FILE: rtl/lcar_pkg.sv
// ============================================================================
// Load cell reader package
// Shared types, codes and constants of the load cell reader and its divider.
// ============================================================================
package lcar_pkg;

    // Default number of data bits clocked out of the converter per reading.
    localparam int unsigned SAMPLE_BITS_DEF = 24;

    // Width of the tare count, which is also the divisor width.
    localparam int unsigned TARE_W = 8;

    // Width of the result value and of the stored offset.
    localparam int unsigned VAL_W = 26;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 26'sh1FFFFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 26'sh2000000;

    // Configuration register reset values.
    localparam logic [1:0]  GAIN_RST    = 2'd1;
    localparam logic [23:0] TIMEOUT_RST = 24'd1000000;

    // Configuration register selects (byte address bit 2).
    localparam logic REG_GAIN    = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW
    } t_phase;

    typedef enum logic [1:0] {
        OP_IDLE,
        OP_READ,
        OP_TARE,
        OP_LOAD
    } t_op;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_TARE = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_TIMEOUT   = 2'd1;
    localparam logic [1:0] STAT_TARE_ZERO = 2'd2;

endpackage

FILE: rtl/load_cell_adc_reader_with_tare.sv
// ============================================================================
// Load cell converter reader with tare
// Two-wire serial reader of a load cell converter, with offset and tare.
// ============================================================================
// Every input word is one half-period tick of the converter's serial clock.
// The tuser field carries the operation (idle, start read, start tare, load
// offset); tdata carries the sampled data line level, the tare count and the
// offset to load. For every input word exactly one output word comes back:
// the serial clock level to drive for this tick, the busy flag, the kind of
// result finished on this tick (in tuser), the value and a status code.
// An ordinary tick's output word is registered, so a word is accepted every
// cycle while the receiver keeps up and no tare division runs; a new word
// is taken even while the previous output word is being handed over.
// The tick that completes a tare runs the average through a bit-serial
// divider: that word's result is loaded into the output register when the
// divider is done, and no input is taken meanwhile.
// If the receiver stalls, the pending output word holds and input stops
// once the output register is full. Reset returns the sequencer to idle,
// clears the offset and restores gain_pulses to 1 and timeout_ticks to
// 1000000. The configuration port holds gain_pulses at byte address 0 and
// timeout_ticks at byte address 4. Write only while idle; nothing checks it.
// ============================================================================
module load_cell_adc_reader_with_tare
    import lcar_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input words.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [0] data_line, [8:1] tare_readings, [33:9] offset_value, [39:34] zero
    input  logic [39:0] i_s_tdata,
    // [1:0] operation
    input  logic [1:0]  i_s_tuser,

    // Output words.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] clock_line, [1] busy_res, [27:2] result_value, [29:28] status,
    // [31:30] zero
    output logic [31:0] o_m_tdata,
    // [1:0] result_kind
    output logic [1:0]  o_m_tuser,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Counter reaches SAMPLE_BITS plus up to three gain pulses.
    localparam int unsigned CW = $clog2(SAMPLE_BITS + 4);
    // Tare sum holds up to 255 full-scale readings.
    localparam int unsigned SW = SAMPLE_BITS + TARE_W;
    // Width that holds a reading minus an offset without overflow.
    localparam int unsigned DW = ((SAMPLE_BITS > VAL_W) ? SAMPLE_BITS : VAL_W) + 2;
    // Width for comparing the tare average with the value limit.
    localparam int unsigned EW = (SW > VAL_W + 1) ? SW : VAL_W + 1;

    localparam logic signed [DW-1:0] D_MAX = DW'(VAL_MAX);
    localparam logic signed [DW-1:0] D_MIN = DW'(VAL_MIN);
    localparam logic [EW-1:0]        E_MAX = EW'(VAL_MAX);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]  r_gain;
    logic [23:0] r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= GAIN_RST;
            r_timeout <= TIMEOUT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_GAIN:    r_gain    <= pwdata[1:0];
                REG_TIMEOUT: r_timeout <= pwdata[23:0];
                default:     r_gain    <= r_gain;
            endcase
        end
    end

    // Reads at word-aligned addresses return the register; others read zero.
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                REG_GAIN:    prdata = {30'd0, r_gain};
                REG_TIMEOUT: prdata = {8'd0, r_timeout};
                default:     prdata = '0;
            endcase
        end
    end

    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    t_phase                   r_phase, n_phase;
    logic [CW-1:0]            r_bit_cnt, n_bit_cnt;
    logic [SAMPLE_BITS-1:0]   r_shift, n_shift;
    logic [23:0]              r_wait, n_wait;
    logic [TARE_W-1:0]        r_tare_rem, n_tare_rem;
    logic [TARE_W-1:0]        r_tare_tot, n_tare_tot;
    logic [SW-1:0]            r_sum, n_sum;
    logic signed [VAL_W-1:0]  r_offset, n_offset;
    logic                     r_in_tare, n_in_tare;

    // Output register.
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_clk, n_out_clk;
    logic                     r_out_busy, n_out_busy;
    logic [1:0]               r_out_kind, n_out_kind;
    logic signed [VAL_W-1:0]  r_out_value, n_out_value;
    logic [1:0]               r_out_status, n_out_status;

    // Input word fields.
    t_op                      in_op;
    logic                     in_dl;
    logic [TARE_W-1:0]        in_nread;
    logic [24:0]              in_offset;

    // Divider handshake.
    logic                     div_start;
    logic                     div_busy;
    logic                     div_done;
    logic [SW-1:0]            div_quot;

    // Scratch values of the tick being processed.
    logic                     accept;
    logic [23:0]              wait_inc;
    logic [CW-1:0]            bit_inc;
    logic [SAMPLE_BITS-1:0]   reading;
    logic [TARE_W-1:0]        rem_dec;
    logic signed [DW-1:0]     diff;
    logic [EW-1:0]            quot_ext;
    logic signed [VAL_W-1:0]  avg_sat;
    logic                     tick_clk;
    logic [1:0]               tick_kind;
    logic [1:0]               tick_status;
    logic signed [VAL_W-1:0]  tick_value;

    assign in_op     = t_op'(i_s_tuser[1:0]);
    assign in_dl     = i_s_tdata[0];
    assign in_nread  = i_s_tdata[8:1];
    assign in_offset = i_s_tdata[33:9];

    assign o_s_tready = !div_busy && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    lcar_div #(
        .WIDTH (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (r_tare_tot),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // The average is never negative, so only the upper limit applies.
    always_comb begin
        quot_ext = EW'(div_quot);
        if (quot_ext > E_MAX) begin
            avg_sat = VAL_MAX;
        end else begin
            avg_sat = VAL_W'(quot_ext);
        end
    end

    // ------------------------------------------------------------------
    // Next state and tick result
    // ------------------------------------------------------------------
    always_comb begin
        n_phase     = r_phase;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_wait      = r_wait;
        n_tare_rem  = r_tare_rem;
        n_tare_tot  = r_tare_tot;
        n_sum       = r_sum;
        n_offset    = r_offset;
        n_in_tare   = r_in_tare;
        tick_clk    = 1'b0;
        tick_kind   = KIND_NONE;
        tick_status = STAT_OK;
        tick_value  = '0;
        div_start   = 1'b0;
        wait_inc    = r_wait + 24'd1;
        bit_inc     = r_bit_cnt + CW'(1);
        rem_dec     = (r_tare_rem != '0) ? r_tare_rem - TARE_W'(1) : r_tare_rem;
        if (r_bit_cnt < CW'(SAMPLE_BITS)) begin
            n_shift = {r_shift[SAMPLE_BITS-2:0], in_dl};
        end
        // Offset binary: flipping the top bit makes the reading unsigned.
        reading     = n_shift ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        diff        = $signed(DW'(reading)) - DW'(r_offset);
        n_shift     = r_shift;

        if (accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    unique case (in_op)
                        OP_READ: begin
                            n_in_tare = 1'b0;
                            n_shift   = '0;
                            n_wait    = '0;
                            n_phase   = PH_WAIT;
                        end
                        OP_TARE: begin
                            if (in_nread == '0) begin
                                tick_kind   = KIND_TARE;
                                tick_status = STAT_TARE_ZERO;
                                tick_value  = r_offset;
                            end else begin
                                n_in_tare  = 1'b1;
                                n_tare_rem = in_nread;
                                n_tare_tot = in_nread;
                                n_sum      = '0;
                                n_shift    = '0;
                                n_wait     = '0;
                                n_phase    = PH_WAIT;
                            end
                        end
                        OP_LOAD: begin
                            n_offset = {in_offset[24], in_offset};
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                PH_WAIT: begin
                    // Data ready is signalled by the data line going low.
                    if (!in_dl) begin
                        n_bit_cnt = '0;
                        n_shift   = '0;
                        n_phase   = PH_HIGH;
                    end else begin
                        n_wait = wait_inc;
                        if (wait_inc >= r_timeout) begin
                            tick_kind   = r_in_tare ? KIND_TARE : KIND_READ;
                            tick_status = STAT_TIMEOUT;
                            n_tare_rem  = '0;
                            n_phase     = PH_IDLE;
                        end
                    end
                end
                PH_HIGH: begin
                    tick_clk = 1'b1;
                    n_phase  = PH_LOW;
                end
                PH_LOW: begin
                    // Sample after the falling edge; gain pulses shift nothing.
                    if (r_bit_cnt < CW'(SAMPLE_BITS)) begin
                        n_shift = {r_shift[SAMPLE_BITS-2:0], in_dl};
                    end
                    n_bit_cnt = bit_inc;
                    if (bit_inc < CW'(SAMPLE_BITS) + CW'(r_gain)) begin
                        n_phase = PH_HIGH;
                    end else if (r_in_tare) begin
                        n_sum      = r_sum + SW'(reading);
                        n_tare_rem = rem_dec;
                        if (rem_dec != '0) begin
                            n_wait  = '0;
                            n_phase = PH_WAIT;
                        end else begin
                            // The average goes through the divider; its
                            // result word is loaded when the divider is done.
                            div_start = 1'b1;
                            n_phase   = PH_IDLE;
                        end
                    end else begin
                        tick_kind = KIND_READ;
                        if (diff > D_MAX) begin
                            tick_value = VAL_MAX;
                        end else if (diff < D_MIN) begin
                            tick_value = VAL_MIN;
                        end else begin
                            tick_value = VAL_W'(diff);
                        end
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (div_done) begin
            n_offset = avg_sat;
        end
    end

    // Output register: loaded by an ordinary tick, or by the divider once a
    // tare average is ready; otherwise emptied when the receiver takes it.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_clk    = r_out_clk;
        n_out_busy   = r_out_busy;
        n_out_kind   = r_out_kind;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        if (accept && !div_start) begin
            n_out_valid  = 1'b1;
            n_out_clk    = tick_clk;
            n_out_busy   = (n_phase != PH_IDLE);
            n_out_kind   = tick_kind;
            n_out_value  = tick_value;
            n_out_status = tick_status;
        end else if (div_done) begin
            n_out_valid  = 1'b1;
            n_out_clk    = 1'b0;
            n_out_busy   = 1'b0;
            n_out_kind   = KIND_TARE;
            n_out_value  = avg_sat;
            n_out_status = STAT_OK;
        end else if (i_m_tready) begin
            n_out_valid  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_wait      <= '0;
            r_tare_rem  <= '0;
            r_tare_tot  <= '0;
            r_sum       <= '0;
            r_offset    <= '0;
            r_in_tare   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_bit_cnt   <= n_bit_cnt;
            r_shift     <= n_shift;
            r_wait      <= n_wait;
            r_tare_rem  <= n_tare_rem;
            r_tare_tot  <= n_tare_tot;
            r_sum       <= n_sum;
            r_offset    <= n_offset;
            r_in_tare   <= n_in_tare;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_clk    <= n_out_clk;
        r_out_busy   <= n_out_busy;
        r_out_kind   <= n_out_kind;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_status, r_out_value, r_out_busy, r_out_clk};
    assign o_m_tuser  = r_out_kind;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // While the tare average is being computed the sequencer rests in idle
    // and no input word is taken.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_phase == PH_IDLE) && !o_s_tready)
        else $error("input taken or sequencer active during tare division");

    // A word that finishes nothing carries a zero value and an ok status.
    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_NONE)) |->
            (r_out_value == '0) && (r_out_status == STAT_OK))
        else $error("empty result word carries a value or status");

    // The clock pin is high only on a tick taken in the high phase.
    a_clk_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !div_start && (r_phase != PH_HIGH)) |=> !r_out_clk)
        else $error("serial clock driven high outside the high phase");

    // The bit counter never runs past the data bits and gain pulses.
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= CW'(SAMPLE_BITS + 3))
        else $error("bit counter out of range");

    // A finished divider always hands a word to an empty output register.
    a_div_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> !r_out_valid)
        else $error("tare result would overwrite a pending word");

endmodule

FILE: rtl/lcar_div.sv
// ============================================================================
// Load cell reader divider
// Bit-serial restoring divider of an unsigned sum by an unsigned tare count.
// ============================================================================
module lcar_div
    import lcar_pkg::*;
#(
    parameter int unsigned WIDTH = SAMPLE_BITS_DEF + TARE_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WIDTH-1:0]  i_dividend,
    input  logic [TARE_W-1:0] i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [WIDTH-1:0]  o_quotient
);

    localparam int unsigned CNT_W = $clog2(WIDTH);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WIDTH-1:0]  r_acc;
    logic [TARE_W-1:0] r_rem;
    logic [TARE_W-1:0] r_div;

    logic [TARE_W:0]   trial;
    logic              q_bit;
    logic [TARE_W-1:0] n_rem;

    // One quotient bit per cycle: the partial remainder takes the next
    // dividend bit and the divisor is subtracted when it fits.
    always_comb begin
        trial = {r_rem, r_acc[WIDTH-1]};
        q_bit = (trial >= {1'b0, r_div});
        if (q_bit) begin
            n_rem = TARE_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[TARE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_acc <= {r_acc[WIDTH-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy | r_done;
    assign o_done     = r_done;
    assign o_quotient = r_acc;

endmodule
